// ===== design/chroma_key_rotate_pixel_defines.svh =====
// Assertion macros shared by the chroma key design files.
`ifndef CHROMA_KEY_ROTATE_PIXEL_DEFINES_SVH
`define CHROMA_KEY_ROTATE_PIXEL_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while reset is low.
`define CKRP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ckrp assertion failed");
// Checked on every edge, reset included.
`define CKRP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ckrp assertion failed");
`else
`define CKRP_ASSERT(lbl, clk, rst, prop)
`define CKRP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/ckrp_pkg.sv =====
package ckrp_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIM_DEF        = 4096;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int FIFO_DEPTH         = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_ANGLE_DEG    = 3'd2,
    REG_X_OFFSET     = 3'd3,
    REG_Y_OFFSET     = 3'd4,
    REG_GREEN_ABOVE  = 3'd5,
    REG_RED_BELOW    = 3'd6,
    REG_BLUE_BELOW   = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [7:0]  ANGLE_DEG_RST    = 8'd0;
  localparam logic [11:0] X_OFFSET_RST     = 12'd800;
  localparam logic [11:0] Y_OFFSET_RST     = 12'd80;
  localparam logic [7:0]  GREEN_ABOVE_RST  = 8'd160;
  localparam logic [7:0]  RED_BELOW_RST    = 8'd128;
  localparam logic [7:0]  BLUE_BELOW_RST   = 8'd128;

  localparam int COORD_W = 15;

  // Pixel color
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Classification of one request, front to back
  typedef struct packed {
    logic keyed;
    logic last;
    pix_t pix;
  } front_info_t;

  // round(sin(d deg) * 2^16), d = 0..90
  localparam logic [16:0] SIN_TAB16 [91] = '{
    17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
    17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
    17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
    17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
    17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
    17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
    17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
    17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
    17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
    17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
    17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
    17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
    17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // Sine of d degrees (d <= 90), rounded half up to frac fraction bits
  function automatic logic [16:0] trig_scaled(input logic [6:0] d, input int frac);
    logic [16:0] v;
    v = SIN_TAB16[(d > 7'd90) ? 7'd90 : d];
    if (frac >= 16) begin
      return v;
    end
    return (v + (17'd1 << (15 - frac))) >> (16 - frac);
  endfunction

endpackage

// ===== design/ckrp_front.sv =====
`include "chroma_key_rotate_pixel_defines.svh"

module ckrp_front #(
  parameter int MAX_DIM = ckrp_pkg::MAX_DIM_DEF,
  parameter int DW      = $clog2(MAX_DIM)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,     // blue, green, red
  input  logic [12:0]            image_width,
  input  logic [12:0]            image_height,
  input  logic [7:0]             green_above,
  input  logic [7:0]             red_below,
  input  logic [7:0]             blue_below,
  input  logic                   fifo_full,
  output logic                   push,
  output ckrp_pkg::front_info_t  info,
  output logic [DW-1:0]          x,
  output logic [DW-1:0]          y
);

  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int CW   = (DIMW > 13) ? DIMW : 13;

  logic [DW-1:0] column, column_next;
  logic [DW-1:0] rows_done, rows_done_next;
  logic [CW-1:0] w_eff, h_eff;
  logic          row_end;
  ckrp_pkg::pix_t pix;

  assign s_tready = !fifo_full;
  assign push     = s_tvalid && s_tready;
  assign pix      = '{red: s_tdata[23:16], green: s_tdata[15:8], blue: s_tdata[7:0]};

  // Effective frame size, clamped to 1..MAX_DIM
  always_comb begin
    if (image_width == 13'd0) begin
      w_eff = CW'(1);
    end else if (CW'(image_width) > CW'(MAX_DIM)) begin
      w_eff = CW'(MAX_DIM);
    end else begin
      w_eff = CW'(image_width);
    end
    if (image_height == 13'd0) begin
      h_eff = CW'(1);
    end else if (CW'(image_height) > CW'(MAX_DIM)) begin
      h_eff = CW'(MAX_DIM);
    end else begin
      h_eff = CW'(image_height);
    end
  end

  // Classify and place the pixel
  always_comb begin
    row_end    = ((CW + 1)'(column) + (CW + 1)'(1)) >= {1'b0, w_eff};
    info.last  = row_end && (((CW + 1)'(rows_done) + (CW + 1)'(1)) >= {1'b0, h_eff});
    info.keyed = (pix.green > green_above) && (pix.red < red_below) &&
                 (pix.blue < blue_below);
    info.pix   = pix;
    x          = column;
    y          = DW'(h_eff - CW'(1) - CW'(rows_done));
  end

  // Position counters
  always_comb begin
    column_next    = column;
    rows_done_next = rows_done;
    if (clear) begin
      column_next    = '0;
      rows_done_next = '0;
    end else if (push) begin
      if (info.last) begin
        column_next    = '0;
        rows_done_next = '0;
      end else if (row_end) begin
        column_next    = '0;
        rows_done_next = rows_done + DW'(1);
      end else begin
        column_next = column + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      rows_done <= '0;
    end else begin
      column    <= column_next;
      rows_done <= rows_done_next;
    end
  end

  `CKRP_ASSERT_ALWAYS(a_reset_home, clk, rst |=> (column == '0) && (rows_done == '0))
  `CKRP_ASSERT(a_frame_wrap, clk, rst,
    push && info.last && !clear |=> (column == '0) && (rows_done == '0))
  `CKRP_ASSERT(a_last_on_row_end, clk, rst, info.last |-> row_end)

endmodule

// ===== design/ckrp_fifo.sv =====
`include "chroma_key_rotate_pixel_defines.svh"

module ckrp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ckrp_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push, do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  `CKRP_ASSERT(a_count_bound, clk, rst, count <= CNTW'(DEPTH))
  `CKRP_ASSERT(a_no_drop, clk, rst, push |-> !full)
  `CKRP_ASSERT(a_count_up, clk, rst, do_push && !do_pop |=> count == $past(count) + CNTW'(1))

endmodule

// ===== design/ckrp_back.sv =====
`include "chroma_key_rotate_pixel_defines.svh"

module ckrp_back #(
  parameter int MAX_DIM        = ckrp_pkg::MAX_DIM_DEF,
  parameter int TRIG_FRAC_BITS = ckrp_pkg::TRIG_FRAC_BITS_DEF,
  parameter int DW             = $clog2(MAX_DIM)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             angle_deg,
  input  logic [11:0]            x_offset,
  input  logic [11:0]            y_offset,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ckrp_pkg::front_info_t  info,
  input  logic [DW-1:0]          x,
  input  logic [DW-1:0]          y,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [55:0]            m_tdata,  // draw_x, draw_y, out_red, out_green, out_blue
  output logic                   m_tuser,  // visible
  output logic                   m_tlast
);

  localparam int P  = TRIG_FRAC_BITS;
  localparam int TW = P + 2;
  localparam int PW = DW + 1 + TW;
  localparam int SW = PW + 1;
  localparam int CO = ckrp_pkg::COORD_W;

  // Sine/cosine for the current angle, registered
  logic                 ang_neg, cos_neg;
  logic [7:0]           d, ds;
  logic [16:0]          sin_raw, cos_raw;
  logic signed [TW-1:0] sin_s, cos_s, sin_val, cos_val;

  always_comb begin
    ang_neg = angle_deg > 8'd180;
    d       = ang_neg ? angle_deg - 8'd180 : angle_deg;
    ds      = (d > 8'd90) ? 8'd180 - d : d;
    sin_raw = ckrp_pkg::trig_scaled(ds[6:0], P);
    if (d <= 8'd90) begin
      cos_raw = ckrp_pkg::trig_scaled(7'(8'd90 - d), P);
      cos_neg = 1'b0;
    end else begin
      cos_raw = ckrp_pkg::trig_scaled(7'(d - 8'd90), P);
      cos_neg = 1'b1;
    end
    sin_s = signed'({1'b0, sin_raw[P:0]});
    cos_s = signed'({1'b0, cos_raw[P:0]});
    if (ang_neg) begin
      sin_s = -sin_s;
    end
    if (ang_neg ^ cos_neg) begin
      cos_s = -cos_s;
    end
  end

  always_ff @(posedge clk) begin
    sin_val <= sin_s;
    cos_val <= cos_s;
  end

  // Stage A: products
  logic                 a_valid, en;
  ckrp_pkg::front_info_t a_info;
  logic signed [PW-1:0] prod_xc, prod_ys, prod_xs, prod_yc;
  logic signed [DW:0]   x_s, y_s;

  assign en       = !m_tvalid || m_tready;
  assign in_ready = en || !a_valid;
  assign x_s      = signed'({1'b0, x});
  assign y_s      = signed'({1'b0, y});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_info  <= info;
      prod_xc <= x_s * cos_val;
      prod_ys <= y_s * sin_val;
      prod_xs <= x_s * sin_val;
      prod_yc <= y_s * cos_val;
    end
  end

  // Stage B: sums, truncation toward zero, offsets
  localparam logic signed [SW-1:0] RND    = SW'((1 << P) - 1);
  localparam logic signed [SW-1:0] NO_RND = SW'(0);
  logic signed [SW-1:0] sum_x, sum_y, quot_x, quot_y, dx, dy;

  always_comb begin
    sum_x  = SW'(prod_xc) - SW'(prod_ys);
    sum_y  = SW'(prod_xs) + SW'(prod_yc);
    quot_x = (sum_x + (sum_x[SW-1] ? RND : NO_RND)) >>> P;
    quot_y = (sum_y + (sum_y[SW-1] ? RND : NO_RND)) >>> P;
    dx     = quot_x + signed'(SW'(x_offset));
    dy     = quot_y + signed'(SW'(y_offset));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && a_valid) begin
      m_tlast <= a_info.last;
      if (a_info.keyed) begin
        m_tuser <= 1'b0;
        m_tdata <= '0;
      end else begin
        m_tuser <= 1'b1;
        m_tdata <= {2'b00, a_info.pix.blue, a_info.pix.green, a_info.pix.red,
                    dy[CO-1:0], dx[CO-1:0]};
      end
    end
  end

  `CKRP_ASSERT(a_stage_hold, clk, rst, a_valid && !en |=> a_valid)
  `CKRP_ASSERT(a_keyed_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata == '0)
  `CKRP_ASSERT(a_advance, clk, rst, en && a_valid |=> m_tvalid)

endmodule

// ===== design/chroma_key_rotate_pixel.sv =====
// Green-screen chroma key with rotation, one BGR pixel per request.
//
// Input stream s_*: pixels in bottom-up raster order, tdata = blue, green, red.
// Column and row are counted inside; x = column, y = height - 1 - rows done.
// Output stream m_*: tuser = visible; tdata = draw_x, draw_y, red, green, blue
// (position and color are zero for a keyed pixel); tlast marks the last pixel.
// Configuration: cfg_write with cfg_index / cfg_data sets one register per
// clock. Writing the width or height restarts the frame count. Write only
// while no pixel is in flight.
//
// A pixel goes through the queue, stage A and the output register. Throughput
// is one pixel per cycle: a 4-entry queue splits the classifier from the
// two-stage multiply/add path, so the input keeps flowing while the output
// stalls until the queue and both stages are full, then s_tready drops.
// Reset (rst, synchronous) loads the default registers, zeros the counters and
// empties the queue and pipeline.
module chroma_key_rotate_pixel #(
  parameter int MAX_DIM        = ckrp_pkg::MAX_DIM_DEF,
  parameter int TRIG_FRAC_BITS = ckrp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,   // blue, green, red
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [55:0]                     m_tdata,   // draw_x, draw_y, red, green, blue
  output logic                            m_tuser,   // visible
  output logic                            m_tlast,
  input  logic                            cfg_write,
  input  logic [ckrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckrp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW = $clog2(MAX_DIM);
  localparam int FW = $bits(ckrp_pkg::front_info_t) + 2 * DW;

  logic [12:0] image_width, image_height;
  logic [7:0]  angle_deg, green_above, red_below, blue_below;
  logic [11:0] x_offset, y_offset;
  logic        clear;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ckrp_pkg::IMAGE_WIDTH_RST;
      image_height <= ckrp_pkg::IMAGE_HEIGHT_RST;
      angle_deg    <= ckrp_pkg::ANGLE_DEG_RST;
      x_offset     <= ckrp_pkg::X_OFFSET_RST;
      y_offset     <= ckrp_pkg::Y_OFFSET_RST;
      green_above  <= ckrp_pkg::GREEN_ABOVE_RST;
      red_below    <= ckrp_pkg::RED_BELOW_RST;
      blue_below   <= ckrp_pkg::BLUE_BELOW_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ckrp_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        ckrp_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        ckrp_pkg::REG_ANGLE_DEG:    angle_deg    <= cfg_data[7:0];
        ckrp_pkg::REG_X_OFFSET:     x_offset     <= cfg_data[11:0];
        ckrp_pkg::REG_Y_OFFSET:     y_offset     <= cfg_data[11:0];
        ckrp_pkg::REG_GREEN_ABOVE:  green_above  <= cfg_data[7:0];
        ckrp_pkg::REG_RED_BELOW:    red_below    <= cfg_data[7:0];
        ckrp_pkg::REG_BLUE_BELOW:   blue_below   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Size writes restart the frame
  assign clear = cfg_write && ((cfg_index == ckrp_pkg::REG_IMAGE_WIDTH) ||
                               (cfg_index == ckrp_pkg::REG_IMAGE_HEIGHT));

  logic                  push, fifo_full, fifo_valid, pop;
  ckrp_pkg::front_info_t f_info, r_info;
  logic [DW-1:0]         f_x, f_y, r_x, r_y;
  logic [FW-1:0]         fifo_wdata, fifo_rdata;

  ckrp_front #(.MAX_DIM(MAX_DIM), .DW(DW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .clear        (clear),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .image_width  (image_width),
    .image_height (image_height),
    .green_above  (green_above),
    .red_below    (red_below),
    .blue_below   (blue_below),
    .fifo_full    (fifo_full),
    .push         (push),
    .info         (f_info),
    .x            (f_x),
    .y            (f_y)
  );

  assign fifo_wdata = {f_info, f_x, f_y};
  assign {r_info, r_x, r_y} = fifo_rdata;

  ckrp_fifo #(.WIDTH(FW), .DEPTH(ckrp_pkg::FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (fifo_wdata),
    .full  (fifo_full),
    .pop   (pop),
    .valid (fifo_valid),
    .rdata (fifo_rdata)
  );

  logic back_ready;
  assign pop = fifo_valid && back_ready;

  ckrp_back #(.MAX_DIM(MAX_DIM), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .DW(DW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .angle_deg (angle_deg),
    .x_offset  (x_offset),
    .y_offset  (y_offset),
    .in_valid  (fifo_valid),
    .in_ready  (back_ready),
    .info      (r_info),
    .x         (r_x),
    .y         (r_y),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
